/* src/chebyshev_harmonic_waveshaper_assert.svh */
// Assertion macros for the Chebyshev harmonic waveshaper checker.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef CHEBYSHEV_HARMONIC_WAVESHAPER_ASSERT_SVH
`define CHEBYSHEV_HARMONIC_WAVESHAPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/chw_pkg.sv */
// Package for the Chebyshev harmonic waveshaper: widths, constants, the controller
// state type and the command word that passes from controller to datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chw_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int AMP_W      = 16;
   localparam int HARM_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int USER_W     = 2;
   localparam int T_W        = 32;                 // Q2.30 polynomial values
   localparam int PROD_W     = SAMPLE_W + T_W;     // Q3.45 products
   localparam int REC_W      = 35;                 // recurrence result before saturation
   localparam int ACC_W      = 51;                 // weighted sum of up to seven products
   localparam int ASUM_W     = 19;                 // sum of up to seven amplitudes
   localparam int DVS_W      = 18;                 // magnitude of the amplitude sum
   localparam int QUO_W      = 17;                 // quotient bits developed by the divider
   localparam int NUM_W      = ACC_W - 15;         // dividend after dropping the Q15 scale
   localparam int FRAC_SHIFT = 15;
   localparam int REC_SHIFT  = 14;
   localparam int DIV_STEPS  = QUO_W;
   localparam int DIV_CNT_W  = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_HARM = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_BASE = 3'd1;

   localparam logic signed [AMP_W-1:0]  AMP1_RESET = 16'sh7FFF;
   localparam logic signed [T_W-1:0]    Q30_ONE    = 32'sh4000_0000;
   localparam logic signed [PROD_W-1:0] REC_ROUND  = 48'sd8192;
   localparam logic [QUO_W-1:0]         QUO_POS_LIM = 17'd32767;
   localparam logic [QUO_W-1:0]         QUO_NEG_LIM = 17'd32768;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [AMP_W-1:0]    amp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_AMP,
      ST_ACC,
      ST_REC,
      ST_DIV_SETUP,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic {
      MUL_SRC_REC,
      MUL_SRC_AMP
   } mul_src_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_src_type mul_src;
      logic        acc_en;
      logic        rec_en;
      logic        div_init;
      logic        div_step;
      logic        finish;
   } dp_cmd_type;

endpackage

`default_nettype wire

/* src/chw_csr.sv */
// Configuration registers of the waveshaper: harmonic count and amplitude weights.
// Depends on chw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chw_csr #(
   parameter int MAX_HARMONICS = 7
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [chw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [chw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output chw_pkg::amp_type                       amp [MAX_HARMONICS],
   output logic [chw_pkg::HARM_W-1:0]             num_harm
);
   import chw_pkg::*;

   logic [HARM_W-1:0] num_harm_ff, num_harm_in;
   amp_type           amp_ff [MAX_HARMONICS];
   amp_type           amp_in [MAX_HARMONICS];

   // Amplitudes beyond the supported harmonic count are never read, so they are not kept.
   always_comb begin
      num_harm_in = num_harm_ff;
      for (int j = 0; j < MAX_HARMONICS; j++) begin
         amp_in[j] = amp_ff[j];
      end
      if (csr_wr_en) begin
         if (csr_index == CSR_NUM_HARM) begin
            num_harm_in = csr_wdata[HARM_W-1:0];
         end
         for (int j = 0; j < MAX_HARMONICS; j++) begin
            if (csr_index == CSR_AMP_BASE + CSR_IDX_W'(j)) begin
               amp_in[j] = $signed(csr_wdata);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_harm_ff <= HARM_W'(1);
         for (int j = 0; j < MAX_HARMONICS; j++) begin
            amp_ff[j] <= (j == 0) ? AMP1_RESET : '0;
         end
      end else begin
         num_harm_ff <= num_harm_in;
         for (int j = 0; j < MAX_HARMONICS; j++) begin
            amp_ff[j] <= amp_in[j];
         end
      end
   end

   assign num_harm = num_harm_ff;
   assign amp      = amp_ff;

endmodule

`default_nettype wire

/* src/chw_ctrl.sv */
// Sequencing controller of the waveshaper: steps the harmonic loop and the divider,
// and owns both handshakes. Depends on chw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chw_ctrl #(
   parameter int MAX_HARMONICS = 7
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [chw_pkg::HARM_W-1:0]         num_harm,
   output chw_pkg::dp_cmd_type                     cmd,
   output logic [$clog2(MAX_HARMONICS)-1:0]        amp_idx
);
   import chw_pkg::*;

   localparam int IDX_W = $clog2(MAX_HARMONICS);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HARM_W-1:0]     n_eff;
   logic                  last_harm;
   logic                  accept;
   logic                  out_free;
   logic                  div_done;

   assign n_eff     = (num_harm > HARM_W'(MAX_HARMONICS)) ? HARM_W'(MAX_HARMONICS) : num_harm;
   assign last_harm = (HARM_W'(idx_ff) + HARM_W'(1)) == n_eff;
   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign div_done  = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (n_eff == '0) ? ST_DIV_SETUP : ST_MUL_AMP;
            end
         end
         ST_MUL_AMP:   state_in = ST_ACC;
         ST_ACC:       state_in = last_harm ? ST_DIV_SETUP : ST_REC;
         ST_REC:       state_in = ST_MUL_AMP;
         ST_DIV_SETUP: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // The input side is always open here, so a valid word is taken at once.
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_MUL_AMP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_src = MUL_SRC_AMP;
         end
         ST_ACC: begin
            // The product for the next recurrence step overlaps the accumulation.
            cmd.acc_en  = 1'b1;
            cmd.mul_en  = !last_harm;
            cmd.mul_src = MUL_SRC_REC;
         end
         ST_REC:       cmd.rec_en   = 1'b1;
         ST_DIV_SETUP: cmd.div_init = 1'b1;
         ST_DIV:       cmd.div_step = 1'b1;
         ST_FINISH:    cmd.finish   = out_free;
         default:      cmd          = '0;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (state_ff == ST_ACC && !last_harm) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.div_init) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign amp_idx    = idx_ff;

endmodule

`default_nettype wire

/* src/chw_dp.sv */
// Datapath of the waveshaper: shared 16x32 multiplier, Chebyshev recurrence,
// weighted accumulation, restoring divider and output register. Depends on chw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chw_dp #(
   parameter int MAX_HARMONICS = 7
) (
   input  wire logic                               clock,
   input  wire chw_pkg::dp_cmd_type                cmd,
   input  wire logic [$clog2(MAX_HARMONICS)-1:0]   amp_idx,
   input  wire chw_pkg::amp_type                   amp [MAX_HARMONICS],
   input  wire logic [chw_pkg::SAMPLE_W-1:0]       sample,
   output logic [chw_pkg::SAMPLE_W-1:0]            shaped,
   output logic                                    sat_flag,
   output logic                                    zero_flag
);
   import chw_pkg::*;

   sample_type                x_ff, x_in;
   logic signed [T_W-1:0]     tp1_ff, tp1_in;
   logic signed [T_W-1:0]     tp2_ff, tp2_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ASUM_W-1:0]  asum_ff, asum_in;
   logic                      neg_ff, neg_in;
   logic                      ovf_ff, ovf_in;
   logic                      zero_ff, zero_in;
   logic [DVS_W-1:0]          dvs_ff, dvs_in;
   logic [DVS_W-1:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]          nlow_ff, nlow_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic [SAMPLE_W-1:0]       shaped_ff, shaped_in;
   logic                      sat_ff, sat_in;
   logic                      zws_ff, zws_in;

   amp_type                   amp_sel;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic signed [PROD_W-1:0]  mul_res;
   logic signed [PROD_W-1:0]  rec_shift;
   logic signed [REC_W-1:0]   rec_diff;
   logic signed [T_W-1:0]     tk;
   logic [ACC_W-1:0]          acc_mag;
   logic [ASUM_W-1:0]         asum_mag;
   logic [NUM_W-1:0]          num;
   logic [DVS_W:0]            trial;
   logic                      trial_ge;
   logic [QUO_W-1:0]          q_lim;
   logic                      q_sat;
   logic [QUO_W-1:0]          q_mag;
   logic [QUO_W-1:0]          q_signed;

   assign amp_sel = amp[amp_idx];
   assign mul_a   = (cmd.mul_src == MUL_SRC_AMP) ? amp_sel : x_ff;
   assign mul_res = mul_a * tp1_ff;

   // 2*x*T(k-1) in Q2.30 rounded half up, less T(k-2), saturated to 32 bits.
   assign rec_shift = (prod_ff + REC_ROUND) >>> REC_SHIFT;
   assign rec_diff  = REC_W'(rec_shift) - REC_W'(tp2_ff);
   always_comb begin
      if (rec_diff[REC_W-1:T_W-1] == '0 || rec_diff[REC_W-1:T_W-1] == '1) begin
         tk = rec_diff[T_W-1:0];
      end else begin
         tk = rec_diff[REC_W-1] ? {1'b1, {(T_W-1){1'b0}}} : {1'b0, {(T_W-1){1'b1}}};
      end
   end

   assign acc_mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign asum_mag = asum_ff[ASUM_W-1] ? ASUM_W'(-asum_ff) : ASUM_W'(asum_ff);
   assign num      = acc_mag[ACC_W-1:FRAC_SHIFT];

   assign trial    = {rem_ff, nlow_ff[QUO_W-1]};
   assign trial_ge = trial >= {1'b0, dvs_ff};

   assign q_lim    = neg_ff ? QUO_NEG_LIM : QUO_POS_LIM;
   assign q_sat    = ovf_ff || (quo_ff > q_lim);
   assign q_mag    = q_sat ? q_lim : quo_ff;
   assign q_signed = neg_ff ? QUO_W'(-q_mag) : q_mag;

   always_comb begin
      x_in      = x_ff;
      tp1_in    = tp1_ff;
      tp2_in    = tp2_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      asum_in   = asum_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      zero_in   = zero_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      nlow_in   = nlow_ff;
      quo_in    = quo_ff;
      shaped_in = shaped_ff;
      sat_in    = sat_ff;
      zws_in    = zws_ff;

      if (cmd.load) begin
         x_in    = $signed(sample);
         tp1_in  = T_W'($signed(sample)) <<< FRAC_SHIFT;
         tp2_in  = Q30_ONE;
         acc_in  = '0;
         asum_in = '0;
      end
      if (cmd.mul_en) begin
         prod_in = mul_res;
      end
      if (cmd.acc_en) begin
         acc_in  = acc_ff + ACC_W'(prod_ff);
         asum_in = asum_ff + ASUM_W'(amp_sel);
      end
      if (cmd.rec_en) begin
         tp2_in = tp1_ff;
         tp1_in = tk;
      end
      if (cmd.div_init) begin
         // The Q15 scale of the divisor is folded into the dividend, so the divider
         // works on the plain amplitude sum and needs only seventeen quotient bits.
         neg_in  = acc_ff[ACC_W-1] ^ asum_ff[ASUM_W-1];
         zero_in = asum_ff == '0;
         dvs_in  = asum_mag[DVS_W-1:0];
         ovf_in  = num >= NUM_W'({asum_mag[DVS_W-1:0], {QUO_W{1'b0}}});
         rem_in  = num[QUO_W+DVS_W-1:QUO_W];
         nlow_in = num[QUO_W-1:0];
         quo_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in  = trial_ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], trial_ge};
         nlow_in = nlow_ff << 1;
      end
      if (cmd.finish) begin
         if (zero_ff) begin
            shaped_in = '0;
            sat_in    = 1'b0;
            zws_in    = 1'b1;
         end else begin
            shaped_in = q_signed[SAMPLE_W-1:0];
            sat_in    = q_sat;
            zws_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      tp1_ff    <= tp1_in;
      tp2_ff    <= tp2_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      asum_ff   <= asum_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      zero_ff   <= zero_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      nlow_ff   <= nlow_in;
      quo_ff    <= quo_in;
      shaped_ff <= shaped_in;
      sat_ff    <= sat_in;
      zws_ff    <= zws_in;
   end

   assign shaped    = shaped_ff;
   assign sat_flag  = sat_ff;
   assign zero_flag = zws_ff;

endmodule

`default_nettype wire

/* src/chebyshev_harmonic_waveshaper.sv */
// Top level of the Chebyshev harmonic waveshaper.
// Instantiates chw_csr, chw_ctrl and chw_dp; types and constants come from chw_pkg.
//
// Usage. Each word accepted on the req_ channel is one Q1.15 audio sample. The block
// builds the Chebyshev polynomials T1..Tn of the sample, forms the amplitude-weighted
// sum and divides it by the sum of the amplitudes, giving one Q1.15 word on the rsp_
// channel together with a saturation flag and a zero-weight flag.
// Sequence. One 16x32 multiplier is shared by the recurrence and the weighting: for
// each harmonic the block forms the weighted product, accumulates it and, before the
// next harmonic, steps the recurrence. The restoring divider, which develops seventeen
// quotient bits, follows. req_tready is high only while the block is idle, so the block
// does not take a new sample until it is through with the last one.
// Stalls. The result sits in an output register; the block accepts the next sample
// while it waits. If rsp_tready is still low when the next result is ready, the block
// holds it inside and does not take further samples until the old word has gone.
// Reset. The synchronous reset returns the sequencer to idle, drops rsp_tvalid and
// loads the register defaults: one harmonic with weight 32767, all others zero.
// Configuration. csr_wr_en writes csr_wdata to register csr_index (0: harmonic count,
// 1..7: weights of T1..T7) at the clock edge. Writes are to be made only while idle;
// the user must keep to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module chebyshev_harmonic_waveshaper #(
   parameter int MAX_HARMONICS = 7
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input channel. req_tdata: [15:0] input_sample.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [chw_pkg::SAMPLE_W-1:0]      req_tdata,
   // Result channel. rsp_tdata: [15:0] shaped_sample.
   // rsp_tuser: [0] saturated, [1] zero_weight_sum.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [chw_pkg::SAMPLE_W-1:0]           rsp_tdata,
   output logic [chw_pkg::USER_W-1:0]             rsp_tuser,
   // Configuration write port.
   input  wire logic                              csr_wr_en,
   input  wire logic [chw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [chw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import chw_pkg::*;

   amp_type                              amp [MAX_HARMONICS];
   logic [HARM_W-1:0]                    num_harm;
   dp_cmd_type                           cmd;
   logic [$clog2(MAX_HARMONICS)-1:0]     amp_idx;
   logic                                 sat_flag;
   logic                                 zero_flag;

   // Register file: the amplitudes are only read by the datapath. The user must change
   // them only between samples; the block itself does not enforce this.
   chw_csr #(
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .amp       (amp),
      .num_harm  (num_harm)
   );

   // The controller walks the harmonics and the divider bits and owns both handshakes.
   chw_ctrl #(
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .num_harm   (num_harm),
      .cmd        (cmd),
      .amp_idx    (amp_idx)
   );

   // The datapath holds the sample, the last two polynomial values, the sums and the
   // divider, and registers the finished word for the result channel.
   chw_dp #(
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .amp_idx   (amp_idx),
      .amp       (amp),
      .sample    (req_tdata),
      .shaped    (rsp_tdata),
      .sat_flag  (sat_flag),
      .zero_flag (zero_flag)
   );

   assign rsp_tuser = {zero_flag, sat_flag};

endmodule

`default_nettype wire

/* src/chw_checker.sv */
// Port-level checker for the Chebyshev harmonic waveshaper, bound to the top level.
// Depends on chw_pkg and chebyshev_harmonic_waveshaper_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "chebyshev_harmonic_waveshaper_assert.svh"

module chw_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [chw_pkg::SAMPLE_W-1:0]   rsp_tdata,
   input  wire logic [chw_pkg::USER_W-1:0]     rsp_tuser
);

   // A zero amplitude sum gives a silent word that is never marked as clamped.
   `CHW_ASSERT_NOW(a_zero_word, rsp_tvalid && rsp_tuser[1], rsp_tdata == 16'h0000 && !rsp_tuser[0], "zero-weight word is not silent")

   // A clamped word sits on one of the two rails of the Q1.15 range.
   `CHW_ASSERT_NOW(a_sat_rail, rsp_tvalid && rsp_tuser[0], rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000, "saturated word is off the rails")

   // A sample is worked on alone: the input side closes once one is taken.
   `CHW_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second sample taken while busy")

   // A stalled result word holds until it is taken.
   `CHW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind chebyshev_harmonic_waveshaper chw_checker u_chw_checker (.*);

`default_nettype wire

/* test/chebyshev_harmonic_waveshaper_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the Chebyshev harmonic waveshaper: follows the register writes, predicts
// the shaped word of every accepted sample and compares it with every result word.
// Depends on chw_pkg for widths, register indexes and reset defaults.

module chebyshev_harmonic_waveshaper_checker #(
   parameter int MAX_HARMONICS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [chw_pkg::SAMPLE_W-1:0]      req_tdata,    // [15:0] input_sample
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [chw_pkg::SAMPLE_W-1:0]      rsp_tdata,    // [15:0] shaped_sample
   input  logic [chw_pkg::USER_W-1:0]        rsp_tuser,    // [0] saturated, [1] zero_weight_sum
   input  logic                              csr_wr_en,
   input  logic [chw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [chw_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);

   import chw_pkg::*;

   typedef struct packed {
      sample_type shaped;
      logic       saturated;
      logic       zero_weight;
   } shaped_word_type;

   localparam longint T_MAX = 64'sd2147483647;
   localparam longint T_MIN = -64'sd2147483648;

   logic [HARM_W-1:0] harmonic_count;
   amp_type           weights [0:6];
   shaped_word_type   expected_words [$];

   // Builds T1..Tn by the recurrence in Q2.30, weights them and divides by the weight sum.
   function automatic shaped_word_type shape_sample(input sample_type x);
      longint          t_older, t_last, t_new, weighted, weight_total, quotient;
      int              n;
      shaped_word_type w;
      n = harmonic_count;
      if (n > MAX_HARMONICS) n = MAX_HARMONICS;
      t_older = longint'(Q30_ONE);
      t_last = longint'(x) * 32768;
      weighted = 0;
      weight_total = 0;
      for (int k = 1; k <= n; k++) begin
         if (k > 1) begin
            t_new = ((longint'(x) * t_last + 8192) >>> REC_SHIFT) - t_older;
            if (t_new > T_MAX) t_new = T_MAX;
            else if (t_new < T_MIN) t_new = T_MIN;
            t_older = t_last;
            t_last = t_new;
         end
         weighted += longint'(weights[k-1]) * t_last;
         weight_total += longint'(weights[k-1]);
      end
      w.shaped = '0;
      w.saturated = 1'b0;
      w.zero_weight = 1'b0;
      if (weight_total == 0) begin
         w.zero_weight = 1'b1;
      end else begin
         quotient = weighted / (weight_total * 32768);
         if (quotient > 32767) begin
            quotient = 32767;
            w.saturated = 1'b1;
         end else if (quotient < -32768) begin
            quotient = -32768;
            w.saturated = 1'b1;
         end
         w.shaped = sample_type'(quotient);
      end
      return w;
   endfunction

   always @(posedge clock) begin : watch
      shaped_word_type got, want;
      if (reset) begin
         harmonic_count = 3'd1;
         for (int k = 0; k < 7; k++) weights[k] = '0;
         weights[0] = AMP1_RESET;
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_NUM_HARM) harmonic_count = csr_wdata[HARM_W-1:0];
            else weights[csr_index - CSR_AMP_BASE] = amp_type'(csr_wdata);
         end
         if (req_tvalid && req_tready)
            expected_words.push_back(shape_sample(sample_type'(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got.shaped = sample_type'(rsp_tdata);
            got.saturated = rsp_tuser[0];
            got.zero_weight = rsp_tuser[1];
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("shaper: unexpected word %0d sat %0b zero %0b",
                           $signed(got.shaped), got.saturated, got.zero_weight);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.shaped != want.shaped || got.saturated != want.saturated ||
                   got.zero_weight != want.zero_weight) begin
                  if (fail_count < 10)
                     $display("shaper: expected %0d sat %0b zero %0b, got %0d sat %0b zero %0b",
                              $signed(want.shaped), want.saturated, want.zero_weight,
                              $signed(got.shaped), got.saturated, got.zero_weight);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_words.size();
   end

endmodule

/* test/chebyshev_harmonic_waveshaper_tb.sv */
`timescale 1ns / 1ps
// Top of the Chebyshev harmonic waveshaper testbench: clock, reset, stimulus and verdict.
// Depends on chw_pkg, the block and chebyshev_harmonic_waveshaper_checker.

module chebyshev_harmonic_waveshaper_tb;

   import chw_pkg::*;

   // The limit leaves ample headroom over the slowest correct run, with the gaps on both
   // sides included.
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;     // [15:0] input_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;          // [15:0] shaped_sample
   logic [USER_W-1:0]     rsp_tuser;          // [0] saturated, [1] zero_weight_sum
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int words_taken = 0;
   bit gaps_enabled = 1'b1;

   // Register settings to be loaded at the next phase boundary.
   logic [HARM_W-1:0] count_plan;
   amp_type           weight_plan [0:6];

   always #1 clock = ~clock;

   chebyshev_harmonic_waveshaper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   chebyshev_harmonic_waveshaper_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // A hung handshake must not run forever: past the limit the run is declared failed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one sample word after an optional gap and returns at the falling edge after
   // it has been taken. The valid is left high so that back-to-back words need no toggle.
   task automatic send_sample(input sample_type x);
      int gap;
      gap = gaps_enabled ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= x;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Closes a phase: the input goes quiet and every outstanding result word must arrive
   // before the registers may be touched. Each sample yields exactly one word, so an empty
   // scoreboard means the block is idle; a short margin is kept all the same.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Writes the harmonic count and all seven weights. The upper bits of the count word are
   // random, as the block must only look at its low three bits.
   task automatic load_weights();
      logic [CSR_DATA_W-1:0] count_word;
      count_word = CSR_DATA_W'($urandom);
      count_word[HARM_W-1:0] = count_plan;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_NUM_HARM;
      csr_wdata <= count_word;
      @(negedge clock);
      for (int k = 0; k < 7; k++) begin
         csr_index <= CSR_AMP_BASE + CSR_IDX_W'(k);
         csr_wdata <= weight_plan[k];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Draws a register setting of the given flavour: fully random, all weights at one
   // extreme, a weight sum close to zero (which drives the quotient into saturation),
   // a sum of exactly zero, or a single active harmonic. Weights above the harmonic count
   // are left random, since the block must ignore them.
   task automatic plan_random_weights(input int style, input bit high_end);
      int harmonics, partial, target;
      for (int k = 0; k < 7; k++) weight_plan[k] = amp_type'($urandom);
      case (style)
         0: begin
            harmonics = $urandom_range(0, 7);
         end
         1: begin
            harmonics = 7;
            for (int k = 0; k < 7; k++) weight_plan[k] = high_end ? 16'sh7FFF : 16'sh8000;
         end
         2, 3: begin
            harmonics = $urandom_range(2, 7);
            target = (style == 2) ? int'($urandom_range(0, 6)) - 3 : 0;
            partial = 0;
            for (int k = 0; k < harmonics - 1; k++) begin
               weight_plan[k] = amp_type'(int'($urandom_range(0, 4000)) - 2000);
               partial += weight_plan[k];
            end
            weight_plan[harmonics-1] = amp_type'(target - partial);
            if (style == 3 && $urandom_range(0, 2) == 0) harmonics = 0;
         end
         default: begin
            harmonics = $urandom_range(1, 7);
            for (int k = 0; k < harmonics; k++) weight_plan[k] = '0;
            weight_plan[$urandom_range(0, harmonics - 1)] = amp_type'($urandom);
         end
      endcase
      count_plan = harmonics[HARM_W-1:0];
   endtask

   // Samples are mostly uniform over all sixteen bits, with the extremes and the values
   // around zero drawn more often than chance would give them.
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return sample_type'(int'($urandom_range(0, 4)) - 2);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Result side. Before each word the receiver may hold off for a random gap; once in the
   // run it holds off for a long stretch, so that the block's output register fills, the
   // next result backs up inside and the input stalls while the sender keeps offering.
   initial begin : result_sink
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (words_taken == 200) gap = 400;
         else gap = gaps_enabled ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         words_taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int style;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset defaults, T1 alone at full weight, the output follows the input.
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      finish_phase();

      // All seven harmonics at the largest positive weight.
      count_plan = 3'd7;
      for (int k = 0; k < 7; k++) weight_plan[k] = 16'sh7FFF;
      load_weights();
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'sh3039);
      send_sample(16'shA57E);
      finish_phase();

      // A harmonic count of zero mixes nothing, so the weight sum is zero.
      count_plan = 3'd0;
      load_weights();
      send_sample(16'sh4000);
      send_sample(16'shC000);
      finish_phase();

      // Two weights that cancel: the zero weight sum case with harmonics in use.
      count_plan = 3'd2;
      weight_plan[0] = 16'sd1000;
      weight_plan[1] = -16'sd1000;
      load_weights();
      send_sample(16'sh0000);
      send_sample(16'sh7FFF);
      finish_phase();

      // A weight sum of one with large weights drives the quotient past the positive limit.
      weight_plan[0] = 16'sd100;
      weight_plan[1] = -16'sd99;
      load_weights();
      send_sample(16'sh0000);
      send_sample(16'sh2000);
      finish_phase();

      // The same with the signs swapped, which clamps at the negative limit.
      weight_plan[0] = -16'sd98;
      weight_plan[1] = 16'sd99;
      load_weights();
      send_sample(16'sh0000);
      send_sample(16'shE000);
      finish_phase();

      // All seven harmonics at the most negative weight.
      count_plan = 3'd7;
      for (int k = 0; k < 7; k++) weight_plan[k] = 16'sh8000;
      load_weights();
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh5A82);
      finish_phase();

      // Random phases. The first five walk through every flavour of setting, the rest pick
      // one at random. Every third phase runs without gaps on either side.
      for (int phase = 0; phase < 10; phase++) begin
         gaps_enabled = (phase % 3 != 2);
         style = (phase < 5) ? phase : $urandom_range(0, 4);
         plan_random_weights(style, phase < 5);
         load_weights();
         repeat (105) send_sample(pick_sample());
         finish_phase();
      end

      // All words are in; allow a further stretch of the block's latency for strays.
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/chw_pkg.sv
src/chw_csr.sv
src/chw_ctrl.sv
src/chw_dp.sv
src/chebyshev_harmonic_waveshaper.sv
src/chw_checker.sv
test/chebyshev_harmonic_waveshaper_checker.sv
test/chebyshev_harmonic_waveshaper_tb.sv
